// ===== rtl/iirf_pkg.sv =====
`default_nettype none

package iirf_pkg;

  // Widths fixed by the sample, coefficient and result formats.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PROD_W   = COEF_W + DATA_W;
  // Up to five products of at most 2^46 magnitude plus the sample fit in 52 bits.
  localparam int unsigned ACC_W    = PROD_W + 4;

  localparam int unsigned TAP_NUM  = 4;
  localparam int unsigned TAP_W    = $clog2(TAP_NUM);
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_NUM - 1);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF_BASE = 3'd4;

  // Feedforward coefficient applied to the new intermediate value.
  localparam logic signed [COEF_W-1:0] FF_COEFF_ZERO = 16'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC_LAST,
    ST_SAT_W,
    ST_MUL_W,
    ST_ADD_W,
    ST_DONE
  } iirf_state_e;

  typedef struct packed {
    logic             load;
    logic             mul;
    logic             acc;
    logic             sat_w;
    logic             mul_w;
    logic             add_w;
    logic             finish;
    logic [TAP_W-1:0] tap;
  } iirf_cmd_t;

  typedef struct packed {
    logic out_free;
  } iirf_sts_t;

  // Clamps a wide signed sum to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
    logic all_one;
    logic all_zero;
    all_one  = &a[ACC_W-1:DATA_W-1];
    all_zero = ~|a[ACC_W-1:DATA_W-1];
    if (all_one || all_zero) begin
      sat32 = a[DATA_W-1:0];
    end else if (a[ACC_W-1]) begin
      sat32 = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
    ext_prod = {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iir_fourth_order_filter_top.sv =====
`default_nettype none

// Fourth-order direct form II IIR filter for signed 16-bit samples. Each
// transaction on the slave stream carries one sample x; the block forms
// w = x + b1*w1 + b2*w2 + b3*w3 + b4*w4, saturates it to signed 32 bits, then
// forms y = a0*w + a1*w1 + ... + a4*w4, saturates y to signed 32 bits and
// sends it as one transaction on the master stream. The same saturated w is
// then pushed onto the four-entry delay line. Coefficients b1..b4 live at
// register indexes 0..3 and a1..a4 at indexes 4..7; they reset to zero and
// should only be written while no sample is in flight. One sample is worked
// on at a time: the next sample can be accepted only after the four delay
// taps have gone one per cycle through a shared pair of 16x32 multipliers,
// followed by the saturation of w, the a0 product, its accumulation and the
// output load. A result waiting in the output register does not block the
// next sample; the block only stalls at the output load if that register
// is still full.
module iir_fourth_order_filter_top
  import iirf_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write port.
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [COEF_W-1:0]      cfg_wdata_i,
  // Input stream.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample_in
  // Output stream.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [DATA_W-1:0]           m_axis_tdata    // [31:0] sample_out
);

  iirf_cmd_t cmd;
  iirf_sts_t sts;
  logic signed [DATA_W-1:0] sample_out;

  // The controller sequences the taps and the saturation steps.
  iirf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds coefficients, delay line, multipliers, accumulators
  // and the output register.
  iirf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_in_i  (signed'(s_axis_tdata)),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .sample_out_o (sample_out)
  );

  assign m_axis_tdata = unsigned'(sample_out);

endmodule

`default_nettype wire

// ===== rtl/iirf_ctrl.sv =====
`default_nettype none

module iirf_ctrl
  import iirf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  iirf_sts_t      sts_i,
  output iirf_cmd_t      cmd_o
);

  iirf_state_e      state_q, state_d;
  logic [TAP_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == TAP_LAST) begin
          state_d = ST_ACC_LAST;
        end
      end
      ST_ACC_LAST: state_d = ST_SAT_W;
      ST_SAT_W:    state_d = ST_MUL_W;
      ST_MUL_W:    state_d = ST_ADD_W;
      ST_ADD_W:    state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    cmd_o.tap  = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cmd_o.acc = (cnt_q != '0);
      end
      ST_ACC_LAST: cmd_o.acc    = 1'b1;
      ST_SAT_W:    cmd_o.sat_w  = 1'b1;
      ST_MUL_W:    cmd_o.mul_w  = 1'b1;
      ST_ADD_W:    cmd_o.add_w  = 1'b1;
      ST_DONE:     cmd_o.finish = sts_i.out_free;
      default:     cmd_o        = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/iirf_datapath.sv =====
`default_nettype none

module iirf_datapath
  import iirf_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [COEF_W-1:0]           cfg_wdata_i,
  input  wire logic signed [SAMPLE_W-1:0]  sample_in_i,
  input  iirf_cmd_t                        cmd_i,
  output iirf_sts_t                        sts_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic signed [DATA_W-1:0]         sample_out_o
);

  logic signed [COEF_W-1:0] fb_q [TAP_NUM];
  logic signed [COEF_W-1:0] ff_q [TAP_NUM];
  logic signed [DATA_W-1:0] dly_q [TAP_NUM];

  logic signed [PROD_W-1:0] prod_fb_q, prod_ff_q;
  logic signed [ACC_W-1:0]  acc_w_q, acc_y_q;
  logic signed [DATA_W-1:0] w_q;
  logic signed [DATA_W-1:0] out_data_q;
  logic                     out_valid_q;

  logic signed [DATA_W-1:0] tap_val;
  logic                     cfg_is_fb;

  assign tap_val   = dly_q[cmd_i.tap];
  assign cfg_is_fb = (cfg_idx_i < REG_FF_BASE);

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAP_NUM; i++) begin
        fb_q[i] <= '0;
        ff_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_is_fb) begin
        fb_q[cfg_idx_i[TAP_W-1:0] - REG_FB_BASE[TAP_W-1:0]] <= cfg_wdata_i;
      end else begin
        ff_q[cfg_idx_i[TAP_W-1:0] - REG_FF_BASE[TAP_W-1:0]] <= cfg_wdata_i;
      end
    end
  end

  // Delay line: shifts once per sample, newest value at the front.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAP_NUM; i++) begin
        dly_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      for (int i = TAP_NUM - 1; i > 0; i--) begin
        dly_q[i] <= dly_q[i-1];
      end
      dly_q[0] <= w_q;
    end
  end

  // Product registers and accumulators.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_fb_q <= PROD_W'(fb_q[cmd_i.tap] * tap_val);
      prod_ff_q <= PROD_W'(ff_q[cmd_i.tap] * tap_val);
    end else if (cmd_i.mul_w) begin
      prod_ff_q <= PROD_W'(FF_COEFF_ZERO * w_q);
    end

    if (cmd_i.load) begin
      acc_w_q <= {{(ACC_W-SAMPLE_W){sample_in_i[SAMPLE_W-1]}}, sample_in_i};
      acc_y_q <= '0;
    end else if (cmd_i.acc) begin
      acc_w_q <= acc_w_q + ext_prod(prod_fb_q);
      acc_y_q <= acc_y_q + ext_prod(prod_ff_q);
    end else if (cmd_i.add_w) begin
      acc_y_q <= acc_y_q + ext_prod(prod_ff_q);
    end

    if (cmd_i.sat_w) begin
      w_q <= sat32(acc_w_q);
    end

    if (cmd_i.finish) begin
      out_data_q <= sat32(acc_y_q);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = out_data_q;

endmodule

`default_nettype wire
